@@ hw/rtl/bar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_pkg: shared types and constants for the block average requantizer
// Payload structs for both channels, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package bar_pkg;

   // sample and register field widths
   localparam int SAMPLE_BITS   = 16;
   localparam int MAX_BLOCK_DEF = 16;
   localparam int STEP_W        = 16;
   localparam int RATE_W        = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_IDX_W     = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT_STEP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_LOG2  = 1'd1;

   // register reset values
   localparam logic [STEP_W-1:0] QUANT_STEP_RST = 16'd1;
   localparam logic [RATE_W-1:0] RATE_LOG2_RST  = 3'd0;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
      logic                          end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
      logic                          last_of_run;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_LEFT_GO,
      ST_LEFT_WAIT,
      ST_RIGHT_GO,
      ST_RIGHT_WAIT,
      ST_EMIT
   } state_type;

endpackage

@@ hw/rtl/bar_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_divider: iterative restoring divider, unsigned
// One quotient bit per cycle; done pulses high for a single cycle as the last bit is registered.
// ----------------------------------------------------------------------------
module bar_divider #(
   parameter int NUM_W = 20,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // one restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      done_in = busy_ff && (cnt_ff == CNT_W'(1));

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/block_average_requantizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_requantizer_core: stereo block averager and requantizer
// Sums sample pairs over a block, divides each channel sum by count * step,
// rescales by step and repeats the result pair once per input pair.
//
//   channel  ports                      direction  role
//   req      req_valid/stall/payload    in         sample pairs
//   rsp      rsp_valid/stall/payload    out        requantized pairs
//   csr      csr_write_en/index/data    in         quant_step, rate_log2
//
// An open block accepts each valid pair without a stall. Closing a block forms
// count * step, then runs two passes of the shared restoring divider (one
// quotient bit per cycle, left then right), then emits one result per pair.
// req_stall is high after the closing pair until the last copy transfers. A
// stalled result holds; sync reset clears sums and counters.
// ----------------------------------------------------------------------------
module block_average_requantizer_core #(
   parameter int MAX_BLOCK = bar_pkg::MAX_BLOCK_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bar_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bar_pkg::rsp_payload_type              rsp_payload,
   input  logic                                  csr_write_en,
   input  logic [bar_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bar_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   import bar_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_BLOCK) + 1;
   localparam int MAG_W = SUM_W - 1;
   localparam int DIV_W = CNT_W + STEP_W;
   localparam int LEN_W = (1 << RATE_W) + 1;

   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [RATE_W-1:0]       rate_ff, rate_in;
   logic signed [SUM_W-1:0] lsum_ff, lsum_in;
   logic signed [SUM_W-1:0] rsum_ff, rsum_in;
   logic [CNT_W-1:0]        pairs_ff, pairs_in;
   logic [CNT_W-1:0]        emit_ff, emit_in;
   logic [DIV_W-1:0]        den_ff, den_in;
   logic [SAMPLE_BITS-1:0]  lres_ff, lres_in;
   logic [SAMPLE_BITS-1:0]  rres_ff, rres_in;

   logic [STEP_W-1:0]       step_eff;
   logic [LEN_W-1:0]        raw_len;
   logic [CNT_W-1:0]        blk_len;
   logic signed [SUM_W-1:0] lsum_add;
   logic signed [SUM_W-1:0] rsum_add;
   logic [CNT_W-1:0]        pairs_add;
   logic [SUM_W-1:0]        lneg;
   logic [SUM_W-1:0]        rneg;
   logic [MAG_W-1:0]        lmag;
   logic [MAG_W-1:0]        rmag;
   logic                    div_start;
   logic [MAG_W-1:0]        div_num;
   logic                    div_done;
   logic [MAG_W-1:0]        div_quo;
   logic [MAG_W+STEP_W-1:0] prod;
   logic [SAMPLE_BITS-1:0]  prod_lo;
   logic                    last_copy;

   // shared divider
   bar_divider #(
      .NUM_W (MAG_W),
      .DEN_W (DIV_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // configuration registers
   always_comb begin
      step_in = step_ff;
      rate_in = rate_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_QUANT_STEP: step_in = csr_write_data[STEP_W-1:0];
            CSR_RATE_LOG2:  rate_in = csr_write_data[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // block length and effective step
   always_comb begin
      step_eff = (step_ff == '0) ? STEP_W'(1) : step_ff;
      raw_len  = LEN_W'(1) << rate_ff;
      blk_len  = (raw_len > LEN_W'(MAX_BLOCK)) ? CNT_W'(MAX_BLOCK) : CNT_W'(raw_len);
   end

   // accumulate, magnitudes and rescale product
   always_comb begin
      lsum_add  = lsum_ff + {{(SUM_W - SAMPLE_BITS){req_payload.left_sample[SAMPLE_BITS-1]}},
                             req_payload.left_sample};
      rsum_add  = rsum_ff + {{(SUM_W - SAMPLE_BITS){req_payload.right_sample[SAMPLE_BITS-1]}},
                             req_payload.right_sample};
      pairs_add = pairs_ff + CNT_W'(1);
      lneg      = -lsum_ff;
      rneg      = -rsum_ff;
      lmag      = lsum_ff[SUM_W-1] ? lneg[MAG_W-1:0] : lsum_ff[MAG_W-1:0];
      rmag      = rsum_ff[SUM_W-1] ? rneg[MAG_W-1:0] : rsum_ff[MAG_W-1:0];
      prod      = {{STEP_W{1'b0}}, div_quo} * {{MAG_W{1'b0}}, step_eff};
      prod_lo   = prod[SAMPLE_BITS-1:0];
   end

   assign last_copy = (emit_ff + CNT_W'(1)) == pairs_ff;

   // sequencer; stall is low only in idle, valid high only in emit
   always_comb begin
      state_in  = state_ff;
      lsum_in   = lsum_ff;
      rsum_in   = rsum_ff;
      pairs_in  = pairs_ff;
      emit_in   = emit_ff;
      den_in    = den_ff;
      lres_in   = lres_ff;
      rres_in   = rres_ff;
      div_start = 1'b0;
      div_num   = lmag;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               lsum_in  = lsum_add;
               rsum_in  = rsum_add;
               pairs_in = pairs_add;
               if (pairs_add >= blk_len || req_payload.end_of_stream) begin
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            den_in   = DIV_W'(pairs_ff) * DIV_W'(step_eff);
            state_in = ST_LEFT_GO;
         end
         ST_LEFT_GO: begin
            div_start = 1'b1;
            div_num   = lmag;
            state_in  = ST_LEFT_WAIT;
         end
         ST_LEFT_WAIT: begin
            if (div_done) begin
               lres_in  = lsum_ff[SUM_W-1] ? -prod_lo : prod_lo;
               state_in = ST_RIGHT_GO;
            end
         end
         ST_RIGHT_GO: begin
            div_start = 1'b1;
            div_num   = rmag;
            state_in  = ST_RIGHT_WAIT;
         end
         ST_RIGHT_WAIT: begin
            if (div_done) begin
               rres_in  = rsum_ff[SUM_W-1] ? -prod_lo : prod_lo;
               emit_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (last_copy) begin
                  lsum_in  = '0;
                  rsum_in  = '0;
                  pairs_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= QUANT_STEP_RST;
         rate_ff  <= RATE_LOG2_RST;
         lsum_ff  <= '0;
         rsum_ff  <= '0;
         pairs_ff <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         rate_ff  <= rate_in;
         lsum_ff  <= lsum_in;
         rsum_ff  <= rsum_in;
         pairs_ff <= pairs_in;
         emit_ff  <= emit_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      lres_ff <= lres_in;
      rres_ff <= rres_in;
   end

   // result payload
   always_comb begin
      rsp_payload.left_out    = lres_ff;
      rsp_payload.right_out   = rres_ff;
      rsp_payload.last_of_run = last_copy;
   end

endmodule
